// ----- design/scp_pkg.sv -----
// Package for the smoothed complementarity pair: constants, types, step functions.
`default_nettype none
package scp_pkg;

  // Fixed-point format of the port values
  localparam int FRAC_BITS = 16;

  // Port widths
  localparam int DATA_W = 32;
  localparam int Q_W    = 31;
  localparam int IDX_W  = 2;

  // Internal widths for the Q16.16 format
  localparam int PROD_W = 2 * DATA_W;          // signed rho*xi and d
  localparam int MAG_W  = PROD_W - 1;          // |d|
  localparam int LO_W   = 32;                  // low half of |d| for the partial products
  localparam int HI_W   = MAG_W - LO_W;        // high half of |d|
  localparam int RM_W   = 2 * Q_W;             // rho*mu
  localparam int RAD_W  = 128;                 // d*d + 4*rho*mu
  localparam int ROOT_W = RAD_W / 2;           // e
  localparam int REM_W  = ROOT_W + 3;          // square root remainder
  localparam int NUM_W  = ROOT_W + 1;          // e +/- |d|
  localparam int DIV_W  = Q_W + 1;             // divisor 2*rho and quotient

  // Pipeline shape
  localparam int SQ_STAGES = 32;
  localparam int SQ_STEPS  = ROOT_W / SQ_STAGES;
  localparam int DV_STAGES = 16;
  localparam int DV_STEPS  = DIV_W / DV_STAGES;

  localparam logic [Q_W-1:0] SAT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_RHO = 2'd0,
    CFG_MU  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] q;
  } dv_t;

  // One digit of the restoring square root, two radicand bits in
  function automatic sq_t sqrt_step(sq_t cur, logic [1:0] pair);
    sq_t              nxt;
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] trial;
    t     = {cur.rem[REM_W-3:0], pair};
    trial = {1'b0, cur.root, 2'b01};
    if (t >= trial) begin
      nxt.rem  = t - trial;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = t;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // One bit of the restoring division
  function automatic dv_t div_step(dv_t cur, logic [DIV_W-1:0] dvs, logic nb);
    dv_t            nxt;
    logic [DIV_W:0] t;
    t = {cur.rem, nb};
    if (t >= {1'b0, dvs}) begin
      nxt.rem = DIV_W'(t - {1'b0, dvs});
      nxt.q   = {cur.q[DIV_W-2:0], 1'b1};
    end else begin
      nxt.rem = t[DIV_W-1:0];
      nxt.q   = {cur.q[DIV_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage
`default_nettype wire

// ----- design/smoothed_complementarity_pair.sv -----
// Top level of the smoothed complementarity pair pipeline.
`default_nettype none
// Streams one vector element per cycle: from s and xi and the held rho and mu it forms
// d = s - rho*xi, e = floor(sqrt(d*d + 4*rho*mu)), z = (e-d)/(2 rho), y = (e+d)/(2 rho) and
// rho*y = (e+d)/2, all Q16.16 and saturated at 2^31-1; rho = 0 gives saturated z and y.
// A new element is taken every cycle unless the output stalls; request to result passes five
// stages of products and sums, 32 square root stages of two root bits each, one stage
// forming the numerators and 16 division stages of two quotient bits each, then the output
// register. A stall at the output holds the whole pipeline. Write rho and mu only while
// the pipeline is empty; the last-element flag travels with its element.
module smoothed_complementarity_pair (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  signed [scp_pkg::DATA_W-1:0]  slack_value_i,
  input  wire  signed [scp_pkg::DATA_W-1:0]  multiplier_value_i,
  input  wire                                last_element_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic        [scp_pkg::Q_W-1:0]     primal_z_o,
  output logic        [scp_pkg::Q_W-1:0]     dual_y_o,
  output logic        [scp_pkg::Q_W-1:0]     scaled_dual_o,
  output logic                               end_of_vector_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire         [scp_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire         [scp_pkg::DATA_W-1:0]  cfg_data_i
);

  localparam int SQL = scp_pkg::SQ_STAGES - 1;
  localparam int DVL = scp_pkg::DV_STAGES - 1;

  logic en;

  // Configuration registers
  logic [scp_pkg::Q_W-1:0] penalty_rho_q;
  logic [scp_pkg::Q_W-1:0] barrier_mu_q;
  logic [scp_pkg::DIV_W-1:0] divisor;

  assign cfg_ready_o = 1'b1;
  assign divisor     = {penalty_rho_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      penalty_rho_q <= scp_pkg::Q_W'(65536);
      barrier_mu_q  <= scp_pkg::Q_W'(655);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        scp_pkg::CFG_RHO: penalty_rho_q <= cfg_data_i[scp_pkg::Q_W-1:0];
        scp_pkg::CFG_MU:  barrier_mu_q  <= cfg_data_i[scp_pkg::Q_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless a result waits untaken
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Front stages
  logic                              v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [scp_pkg::DATA_W-1:0] s1_s_q;
  logic signed [scp_pkg::PROD_W-1:0] s1_b_q;
  logic        [scp_pkg::RM_W-1:0]   s1_rm_q;
  logic                              s1_last_q;
  logic signed [scp_pkg::PROD_W-1:0] s1_b_d;
  logic        [scp_pkg::RM_W-1:0]   s1_rm_d;

  logic signed [scp_pkg::PROD_W-1:0] s2_dv;
  logic        [scp_pkg::MAG_W-1:0]  s2_mag_q, s3_mag_q, s4_mag_q, s5_mag_q;
  logic                              s2_neg_q, s3_neg_q, s4_neg_q, s5_neg_q;
  logic                              s2_last_q, s3_last_q, s4_last_q, s5_last_q;
  logic        [scp_pkg::PROD_W-1:0] s2_k_q, s3_k_q;
  logic        [2*scp_pkg::LO_W-1:0] s3_ll_q;
  logic        [2*scp_pkg::HI_W-1:0] s3_hh_q;
  logic        [scp_pkg::MAG_W-1:0]  s4_hl_q;
  logic        [scp_pkg::RAD_W-1:0]  s4_p_q, s5_rad_q;
  logic        [scp_pkg::MAG_W-1:0]  s4_hl_d;
  logic        [2*scp_pkg::LO_W-1:0] s3_ll_d;
  logic        [2*scp_pkg::HI_W-1:0] s3_hh_d;

  assign s1_b_d  = scp_pkg::PROD_W'(multiplier_value_i) *
                   scp_pkg::PROD_W'($signed({1'b0, penalty_rho_q}));
  assign s1_rm_d = penalty_rho_q * barrier_mu_q;
  assign s2_dv   = {{(scp_pkg::PROD_W - scp_pkg::DATA_W - scp_pkg::FRAC_BITS){s1_s_q[scp_pkg::DATA_W-1]}},
                    s1_s_q, {scp_pkg::FRAC_BITS{1'b0}}} - s1_b_q;
  assign s3_ll_d = s2_mag_q[scp_pkg::LO_W-1:0] * s2_mag_q[scp_pkg::LO_W-1:0];
  assign s3_hh_d = s2_mag_q[scp_pkg::MAG_W-1:scp_pkg::LO_W] *
                   s2_mag_q[scp_pkg::MAG_W-1:scp_pkg::LO_W];
  assign s4_hl_d = s3_mag_q[scp_pkg::MAG_W-1:scp_pkg::LO_W] * s3_mag_q[scp_pkg::LO_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1: rho*xi and rho*mu
      s1_s_q    <= slack_value_i;
      s1_b_q    <= s1_b_d;
      s1_rm_q   <= s1_rm_d;
      s1_last_q <= last_element_i;
      // stage 2: d and its magnitude, 4*rho*mu
      s2_mag_q  <= s2_dv[scp_pkg::PROD_W-1] ? scp_pkg::MAG_W'(-s2_dv)
                                             : s2_dv[scp_pkg::MAG_W-1:0];
      s2_neg_q  <= s2_dv[scp_pkg::PROD_W-1];
      s2_k_q    <= {s1_rm_q, 2'b00};
      s2_last_q <= s1_last_q;
      // stage 3: outer partial products of d*d
      s3_ll_q   <= s3_ll_d;
      s3_hh_q   <= s3_hh_d;
      s3_k_q    <= s2_k_q;
      s3_mag_q  <= s2_mag_q;
      s3_neg_q  <= s2_neg_q;
      s3_last_q <= s2_last_q;
      // stage 4: cross product, outer terms plus barrier term
      s4_hl_q   <= s4_hl_d;
      s4_p_q    <= {2'b00, s3_hh_q, s3_ll_q} +
                   {{(scp_pkg::RAD_W - scp_pkg::PROD_W - 2 * scp_pkg::FRAC_BITS){1'b0}},
                    s3_k_q, {(2 * scp_pkg::FRAC_BITS){1'b0}}};
      s4_mag_q  <= s3_mag_q;
      s4_neg_q  <= s3_neg_q;
      s4_last_q <= s3_last_q;
      // stage 5: full radicand
      s5_rad_q  <= s4_p_q + {{(scp_pkg::RAD_W - scp_pkg::MAG_W - scp_pkg::LO_W - 1){1'b0}},
                             s4_hl_q, {(scp_pkg::LO_W + 1){1'b0}}};
      s5_mag_q  <= s4_mag_q;
      s5_neg_q  <= s4_neg_q;
      s5_last_q <= s4_last_q;
    end
  end

  // Square root stages
  logic [scp_pkg::SQ_STAGES-1:0] sq_v_q;
  scp_pkg::sq_t              sq_q     [scp_pkg::SQ_STAGES];
  scp_pkg::sq_t              sq_d     [scp_pkg::SQ_STAGES];
  logic [scp_pkg::RAD_W-1:0] sq_rad_q [scp_pkg::SQ_STAGES];
  logic [scp_pkg::RAD_W-1:0] sq_rad_d [scp_pkg::SQ_STAGES];
  logic [scp_pkg::MAG_W-1:0] sq_mag_q [scp_pkg::SQ_STAGES];
  logic [scp_pkg::SQ_STAGES-1:0] sq_neg_q, sq_last_q;

  always_comb begin
    scp_pkg::sq_t              cur;
    logic [scp_pkg::RAD_W-1:0] rad;
    for (int j = 0; j < scp_pkg::SQ_STAGES; j++) begin
      if (j == 0) begin
        cur = '0;
        rad = s5_rad_q;
      end else begin
        cur = sq_q[j-1];
        rad = sq_rad_q[j-1];
      end
      for (int k = 0; k < scp_pkg::SQ_STEPS; k++) begin
        cur = scp_pkg::sqrt_step(cur, rad[scp_pkg::RAD_W-1 -: 2]);
        rad = rad << 2;
      end
      sq_d[j]     = cur;
      sq_rad_d[j] = rad;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < scp_pkg::SQ_STAGES; j++) begin
        sq_q[j]     <= sq_d[j];
        sq_rad_q[j] <= sq_rad_d[j];
        if (j == 0) begin
          sq_mag_q[j]  <= s5_mag_q;
          sq_neg_q[j]  <= s5_neg_q;
          sq_last_q[j] <= s5_last_q;
        end else begin
          sq_mag_q[j]  <= sq_mag_q[j-1];
          sq_neg_q[j]  <= sq_neg_q[j-1];
          sq_last_q[j] <= sq_last_q[j-1];
        end
      end
    end
  end

  // Numerator stage: e -/+ |d| and the scaled dual
  logic                      p_v_q;
  logic [scp_pkg::NUM_W-1:0] p_nz_q, p_ny_q;
  logic                      p_neg_q, p_last_q;
  logic [scp_pkg::NUM_W-1:0] p_sum, p_diff, p_nz_d, p_ny_d;
  logic [scp_pkg::NUM_W-1:0] p_ysh;
  logic [scp_pkg::Q_W-1:0]   p_scaled_q;

  assign p_sum  = {1'b0, sq_q[SQL].root} + {2'b00, sq_mag_q[SQL]};
  assign p_diff = {1'b0, sq_q[SQL].root} - {2'b00, sq_mag_q[SQL]};
  assign p_nz_d = sq_neg_q[SQL] ? p_sum : p_diff;
  assign p_ny_d = sq_neg_q[SQL] ? p_diff : p_sum;
  assign p_ysh  = p_ny_d >> (scp_pkg::FRAC_BITS + 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_nz_q     <= p_nz_d;
      p_ny_q     <= p_ny_d;
      p_neg_q    <= sq_neg_q[SQL];
      p_last_q   <= sq_last_q[SQL];
      p_scaled_q <= (p_ysh[scp_pkg::NUM_W-1:scp_pkg::Q_W] != '0) ? scp_pkg::SAT_MAX
                                                               : p_ysh[scp_pkg::Q_W-1:0];
    end
  end

  // Division stages, z and y side by side
  logic [scp_pkg::DV_STAGES-1:0] dv_v_q, dv_ovz_q, dv_ovy_q, dv_last_q;
  scp_pkg::dv_t              dvz_q [scp_pkg::DV_STAGES];
  scp_pkg::dv_t              dvy_q [scp_pkg::DV_STAGES];
  scp_pkg::dv_t              dvz_d [scp_pkg::DV_STAGES];
  scp_pkg::dv_t              dvy_d [scp_pkg::DV_STAGES];
  logic [scp_pkg::DIV_W-1:0] dvz_bits_q [scp_pkg::DV_STAGES];
  logic [scp_pkg::DIV_W-1:0] dvy_bits_q [scp_pkg::DV_STAGES];
  logic [scp_pkg::DIV_W-1:0] dvz_bits_d [scp_pkg::DV_STAGES];
  logic [scp_pkg::DIV_W-1:0] dvy_bits_d [scp_pkg::DV_STAGES];
  logic [scp_pkg::Q_W-1:0]   dv_scaled_q [scp_pkg::DV_STAGES];
  logic                      ovz_d, ovy_d;

  // quotient would not fit DIV_W bits; also catches a zero divisor
  assign ovz_d = p_nz_q[scp_pkg::NUM_W-1:scp_pkg::DIV_W] >= {1'b0, divisor};
  assign ovy_d = p_ny_q[scp_pkg::NUM_W-1:scp_pkg::DIV_W] >= {1'b0, divisor};

  always_comb begin
    scp_pkg::dv_t              cz, cy;
    logic [scp_pkg::DIV_W-1:0] bz, by;
    for (int j = 0; j < scp_pkg::DV_STAGES; j++) begin
      if (j == 0) begin
        cz = '{rem: p_nz_q[scp_pkg::NUM_W-2:scp_pkg::DIV_W], q: '0};
        cy = '{rem: p_ny_q[scp_pkg::NUM_W-2:scp_pkg::DIV_W], q: '0};
        bz = p_nz_q[scp_pkg::DIV_W-1:0];
        by = p_ny_q[scp_pkg::DIV_W-1:0];
      end else begin
        cz = dvz_q[j-1];
        cy = dvy_q[j-1];
        bz = dvz_bits_q[j-1];
        by = dvy_bits_q[j-1];
      end
      for (int k = 0; k < scp_pkg::DV_STEPS; k++) begin
        cz = scp_pkg::div_step(cz, divisor, bz[scp_pkg::DIV_W-1]);
        cy = scp_pkg::div_step(cy, divisor, by[scp_pkg::DIV_W-1]);
        bz = bz << 1;
        by = by << 1;
      end
      dvz_d[j]      = cz;
      dvy_d[j]      = cy;
      dvz_bits_d[j] = bz;
      dvy_bits_d[j] = by;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < scp_pkg::DV_STAGES; j++) begin
        dvz_q[j]      <= dvz_d[j];
        dvy_q[j]      <= dvy_d[j];
        dvz_bits_q[j] <= dvz_bits_d[j];
        dvy_bits_q[j] <= dvy_bits_d[j];
        if (j == 0) begin
          dv_ovz_q[j]    <= ovz_d;
          dv_ovy_q[j]    <= ovy_d;
          dv_last_q[j]   <= p_last_q;
          dv_scaled_q[j] <= p_scaled_q;
        end else begin
          dv_ovz_q[j]    <= dv_ovz_q[j-1];
          dv_ovy_q[j]    <= dv_ovy_q[j-1];
          dv_last_q[j]   <= dv_last_q[j-1];
          dv_scaled_q[j] <= dv_scaled_q[j-1];
        end
      end
    end
  end

  // Output register with final saturation
  always_ff @(posedge clk_i) begin
    if (en) begin
      primal_z_o      <= (dv_ovz_q[DVL] || dvz_q[DVL].q[scp_pkg::DIV_W-1]) ? scp_pkg::SAT_MAX
                                                            : dvz_q[DVL].q[scp_pkg::Q_W-1:0];
      dual_y_o        <= (dv_ovy_q[DVL] || dvy_q[DVL].q[scp_pkg::DIV_W-1]) ? scp_pkg::SAT_MAX
                                                            : dvy_q[DVL].q[scp_pkg::Q_W-1:0];
      scaled_dual_o   <= dv_scaled_q[DVL];
      end_of_vector_o <= dv_last_q[DVL];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      sq_v_q      <= '0;
      p_v_q       <= 1'b0;
      dv_v_q      <= '0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      sq_v_q      <= {sq_v_q[scp_pkg::SQ_STAGES-2:0], v5_q};
      p_v_q       <= sq_v_q[SQL];
      dv_v_q      <= {dv_v_q[scp_pkg::DV_STAGES-2:0], p_v_q};
      out_valid_o <= dv_v_q[DVL];
    end
  end

  // A stall freezes the pipeline occupancy
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(sq_v_q) && $stable(dv_v_q) && $stable(p_v_q))
    else $error("pipeline moved during a stall");

  // For d not negative the y numerator is never below the z numerator
  a_num_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_v_q && !p_neg_q |-> p_ny_q >= p_nz_q)
    else $error("numerator order broken");

  // A new result only comes from an occupied last division stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(dv_v_q[DVL]) && $past(en))
    else $error("result without a source");

endmodule
`default_nettype wire

// ----- sim/scp_checker.sv -----
// Checker for the smoothed complementarity pair: predicts each request's result and compares.
`default_nettype none
module scp_checker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  input  wire                          in_ready_i,
  input  wire  [scp_pkg::DATA_W-1:0]   slack_value_i,
  input  wire  [scp_pkg::DATA_W-1:0]   multiplier_value_i,
  input  wire                          last_element_i,
  input  wire                          out_valid_i,
  input  wire                          out_ready_i,
  input  wire  [scp_pkg::Q_W-1:0]      primal_z_i,
  input  wire  [scp_pkg::Q_W-1:0]      dual_y_i,
  input  wire  [scp_pkg::Q_W-1:0]      scaled_dual_i,
  input  wire                          end_of_vector_i,
  input  wire                          cfg_valid_i,
  input  wire                          cfg_ready_i,
  input  wire  [scp_pkg::IDX_W-1:0]    cfg_index_i,
  input  wire  [scp_pkg::DATA_W-1:0]   cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import scp_pkg::*;

  typedef struct packed {
    logic [Q_W-1:0] primal_z;
    logic [Q_W-1:0] dual_y;
    logic [Q_W-1:0] scaled_dual;
    logic           end_of_vector;
  } pair_res_t;

  logic [Q_W-1:0] rho_q;
  logic [Q_W-1:0] mu_q;
  pair_res_t      pair_queue[$];

  // saturate a wide unsigned value at 2^31-1
  function automatic logic [Q_W-1:0] sat_q(logic [127:0] v);
    if (v > 128'(SAT_MAX)) return SAT_MAX;
    return v[Q_W-1:0];
  endfunction

  // expected z, y and rho*y for one element
  function automatic pair_res_t predict_pair(logic signed [31:0] s, logic signed [31:0] xi,
                                             logic last, logic [Q_W-1:0] rho,
                                             logic [Q_W-1:0] mu);
    pair_res_t          r;
    logic [63:0]        s_mag, xi_mag, d_mag, e, cand, rm;
    logic signed [63:0] sa, sb, d;
    logic [127:0]       rad, nz, ny, dvs;
    s_mag  = (s < 0) ? -64'(s) : 64'(s);
    xi_mag = (xi < 0) ? -64'(xi) : 64'(xi);
    sa = signed'(s_mag << FRAC_BITS);
    if (s < 0) sa = -sa;
    sb = signed'(64'(rho) * xi_mag);
    if (xi < 0) sb = -sb;
    d = sa - sb;
    d_mag = (d < 0) ? 64'(-d) : 64'(d);
    rm = 64'(rho) * 64'(mu);
    rm = rm << 2;
    rad = 128'(d_mag) * 128'(d_mag) + (128'(rm) << (2 * FRAC_BITS));
    // floor square root, one bit at a time
    e = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = e | (64'd1 << i);
      if (128'(cand) * 128'(cand) <= rad) e = cand;
    end
    if (d < 0) begin
      nz = 128'(e) + 128'(d_mag);
      ny = 128'(e - d_mag);
    end else begin
      nz = 128'(e - d_mag);
      ny = 128'(e) + 128'(d_mag);
    end
    dvs = 128'(rho) << 1;
    r.primal_z      = (dvs == 0) ? SAT_MAX : sat_q(nz / dvs);
    r.dual_y        = (dvs == 0) ? SAT_MAX : sat_q(ny / dvs);
    r.scaled_dual   = sat_q(ny >> (FRAC_BITS + 1));
    r.end_of_vector = last;
    return r;
  endfunction

  task automatic report(string what, logic [Q_W-1:0] got, logic [Q_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  // register copy, predictions and comparisons
  always @(posedge clk_i or negedge rst_ni) begin
    pair_res_t want;
    if (!rst_ni) begin
      rho_q = 31'd65536;
      mu_q  = 31'd655;
      pair_queue.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_RHO) rho_q = cfg_data_i[Q_W-1:0];
        else if (cfg_index_i == CFG_MU) mu_q = cfg_data_i[Q_W-1:0];
      end
      if (in_valid_i && in_ready_i)
        pair_queue.push_back(predict_pair(slack_value_i, multiplier_value_i,
                                          last_element_i, rho_q, mu_q));
      if (out_valid_i && out_ready_i) begin
        if (pair_queue.size() == 0) begin
          $display("unexpected result at %0t", $time);
          fail_count_o++;
        end else begin
          want = pair_queue.pop_front();
          if (primal_z_i !== want.primal_z) report("primal_z", primal_z_i, want.primal_z);
          if (dual_y_i !== want.dual_y) report("dual_y", dual_y_i, want.dual_y);
          if (scaled_dual_i !== want.scaled_dual)
            report("scaled_dual", scaled_dual_i, want.scaled_dual);
          if (end_of_vector_i !== want.end_of_vector)
            report("end_of_vector", 31'(end_of_vector_i), 31'(want.end_of_vector));
        end
      end
    end
    pending_o = pair_queue.size();
  end

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Stimulus and verdict for the smoothed complementarity pair.
`default_nettype none
module testbench;
  import scp_pkg::*;

  localparam logic [IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [31:0]      S_MAX = 32'h7fff_ffff;
  localparam logic [31:0]      S_MIN = 32'h8000_0000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] slack = '0;
  logic [DATA_W-1:0] mult = '0;
  logic              last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [Q_W-1:0]    primal_z, dual_y, scaled_dual;
  logic              eov;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = CFG_RHO;
  logic [DATA_W-1:0] cfg_data = '0;
  int                fail_count, pending;
  int                send_idle = 0, recv_idle = 0;
  int                hold_req = 0;

  always #1 clk_i = ~clk_i;

  smoothed_complementarity_pair u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .slack_value_i(slack), .multiplier_value_i(mult), .last_element_i(last),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .primal_z_o(primal_z), .dual_y_o(dual_y), .scaled_dual_o(scaled_dual),
    .end_of_vector_o(eov),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  scp_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .slack_value_i(slack), .multiplier_value_i(mult), .last_element_i(last),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .primal_z_i(primal_z), .dual_y_i(dual_y), .scaled_dual_i(scaled_dual),
    .end_of_vector_i(eov),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random back-pressure, plus long hold-offs on request
  initial begin
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && holds_done != hold_req) begin
        holds_done++;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // one request on the element channel; returns at a falling edge
  task automatic send_pair(logic [31:0] s, logic [31:0] xi, logic l);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    slack = s;
    mult = xi;
    last = l;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drain the pipeline, then write one register
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] value);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_value(int kind);
    logic [31:0] v;
    case (kind)
      0: v = $urandom;
      1: v = $urandom_range(0, 1 << 20);
      default: v = $urandom_range(0, 1 << 12);
    endcase
    if (kind != 0 && $urandom_range(1)) v = -v;
    return v;
  endfunction

  function automatic logic [31:0] rand_reg(bit allow_zero);
    case ($urandom_range(4))
      0: return allow_zero ? 32'd0 : 32'd1;
      1: return S_MAX;
      2: return 32'd65536;
      3: return $urandom_range(1, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int k;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes at reset settings
    send_pair(32'd0, 32'd0, 1'b0);
    send_pair(S_MAX, S_MAX, 1'b0);
    send_pair(S_MIN, S_MIN, 1'b1);
    send_pair(S_MIN, S_MAX, 1'b0);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(32'd0, S_MIN, 1'b0);
    send_pair(S_MAX, 32'd0, 1'b0);
    send_pair(32'hffff_0000, 32'd0, 1'b0);
    send_pair(32'd65536, 32'd65536, 1'b1);
    send_pair(32'hffff_ffff, 32'd1, 1'b0);
    // zero penalty through a wide write: bit 31 is dropped
    write_reg(CFG_RHO, 32'h8000_0000);
    send_pair(32'd65536, 32'd3, 1'b0);
    send_pair(S_MIN, S_MAX, 1'b1);
    // unknown indexes are ignored
    write_reg(CFG_SPARE_A, 32'h1234_5678);
    write_reg(CFG_SPARE_B, 32'hffff_ffff);
    send_pair(32'd0, 32'd0, 1'b0);
    // largest rho and mu: huge intermediates
    write_reg(CFG_RHO, S_MAX);
    write_reg(CFG_MU, 32'hffff_ffff);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(S_MIN, S_MAX, 1'b0);
    send_pair(32'd0, 32'd0, 1'b1);
    // smallest rho, zero mu
    write_reg(CFG_RHO, 32'd1);
    write_reg(CFG_MU, 32'd0);
    send_pair(32'd0, 32'd0, 1'b0);
    send_pair(32'd5, 32'd327680, 1'b1);
    send_pair(S_MAX, S_MAX, 1'b0);

    // random part: three idling phases, three settings each
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 30 : (ph == 1) ? 83 : 0;
      recv_idle = (ph == 0) ? 83 : (ph == 1) ? 30 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        write_reg(CFG_RHO, rand_reg(1'b0));
        write_reg(CFG_MU, rand_reg(1'b1));
        if (ph == 2 && blk == 1) hold_req++;
        for (int n = 0; n < 150; n++) begin
          k = $urandom_range(2);
          send_pair(rand_value(k), rand_value(k), $urandom_range(3) == 0);
          // pause until the pipeline is empty
          if (n == 75) begin
            in_valid = 1'b0;
            while (pending != 0) @(negedge clk_i);
          end
        end
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
